FILE: rtl/core/hmacc_pkg.sv
// Package for the blocked histogram moment accumulator.
// Holds field widths, register codes, reset values and shared types.
// No dependencies.
`default_nettype none

package hmacc_pkg;

   localparam int SampleW   = 16;
   localparam int SqW       = 31;
   localparam int QuadW     = 29;
   localparam int CountW    = 28;
   localparam int MeasW     = 16;
   localparam int NtW       = 13;
   localparam int SiteW     = 12;
   localparam int ScaleW    = 24;
   localparam int NbW       = 7;
   localparam int BinIdxW   = 6;
   localparam int BlockW    = 32;
   localparam int RawBinW   = 12;
   localparam int DivisorW  = 28;
   localparam int DividendW = 59;
   localparam int SumFirstW = 44;
   localparam int SumSecW   = 59;
   localparam int SumFourW  = 58;
   localparam int CsrAddrW  = 5;
   localparam int CsrDataW  = 32;
   localparam int QueueDepth = 4;

   typedef enum logic [2:0] {
      REG_RANGE_LOW  = 3'd0,
      REG_RANGE_HIGH = 3'd1,
      REG_BIN_SCALE  = 3'd2,
      REG_BINS       = 3'd3,
      REG_SITES      = 3'd4,
      REG_MEAS       = 3'd5
   } csr_reg_type;

   localparam logic [15:0] RangeLowReset  = 16'hC000;
   localparam logic [15:0] RangeHighReset = 16'd16384;
   localparam logic [23:0] BinScaleReset  = 24'd524288;
   localparam logic [6:0]  BinsReset      = 7'd64;
   localparam logic [12:0] SitesReset     = 13'd64;
   localparam logic [15:0] MeasReset      = 16'd100;

   typedef struct packed {
      logic signed [SampleW-1:0] range_low;
      logic signed [SampleW-1:0] range_high;
      logic [ScaleW-1:0]         bin_scale;
      logic [NbW-1:0]            bins_in_use;
      logic [NtW-1:0]            sites;
      logic [MeasW-1:0]          meas_per_block;
   } cfg_type;

   typedef struct packed {
      logic                      flush;
      logic signed [SampleW-1:0] sample;
      logic [SqW-1:0]            sq;
      logic [QuadW-1:0]          quad;
      logic                      under;
      logic                      over;
      logic [BinIdxW-1:0]        bin;
   } item_type;

   function automatic logic [NbW-1:0] clamp_bins(input logic [NbW-1:0] n,
                                                 input logic [NbW-1:0] lim);
      logic [NbW-1:0] r;
      r = n;
      if (r == '0) r = NbW'(1);
      if (r > lim) r = lim;
      return r;
   endfunction

   function automatic logic [NtW-1:0] clamp_nt(input logic [NtW-1:0] n);
      logic [NtW-1:0] r;
      r = n;
      if (r < NtW'(2)) r = NtW'(2);
      if (r > NtW'(4096)) r = NtW'(4096);
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/hmacc_if.sv
// Handshake channel interfaces for the accumulator: sample requests and bin results.
// Depends on hmacc_pkg.
`default_nettype none

interface hmacc_req_if
   import hmacc_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic signed [SampleW-1:0] sample;

   modport source (output valid, output mode, output sample, input ready);
   modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface hmacc_rsp_if
   import hmacc_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [BlockW-1:0]         block_index;
   logic [BinIdxW-1:0]        bin_index;
   logic [CountW-1:0]         bin_count;
   logic [CountW-1:0]         under_count;
   logic [CountW-1:0]         over_count;
   logic [MeasW-1:0]          block_meas;
   logic signed [SampleW-1:0] mean_first;
   logic [SqW-1:0]            mean_second;
   logic [QuadW-1:0]          mean_fourth;
   logic                      last_of_block;

   modport source (output valid, output block_index, output bin_index, output bin_count,
                   output under_count, output over_count, output block_meas,
                   output mean_first, output mean_second, output mean_fourth,
                   output last_of_block, input ready);
   modport sink   (input valid, input block_index, input bin_index, input bin_count,
                   input under_count, input over_count, input block_meas,
                   input mean_first, input mean_second, input mean_fourth,
                   input last_of_block, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hmacc_front.sv
// Front end: accepts samples, classifies them and computes powers and bin index.
// Depends on hmacc_pkg and hmacc_if.
`default_nettype none

module hmacc_front
   import hmacc_pkg::*;
#(
   parameter int BINS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   hmacc_req_if.sink    req_if,
   input  wire cfg_type cfg,
   input  wire logic    push_ready,
   output logic         push_valid,
   output item_type     push_item
);

   localparam logic [NbW-1:0] BinsLim = NbW'(BINS);

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_flush_ff;
   logic signed [SampleW-1:0] s1_sample_ff;
   logic                      s2_valid_ff, s2_valid_in;
   logic                      s2_flush_ff;
   logic signed [SampleW-1:0] s2_sample_ff;
   logic [SqW-1:0]            s2_sq_ff;
   logic                      s2_under_ff, s2_over_ff;
   logic [RawBinW-1:0]        s2_raw_ff;

   logic                 s1_move, s2_load;
   logic [SampleW:0]     y_ext, a_ext, diff;
   logic [SampleW-1:0]   mag, bin_offset;
   logic                 under, over;
   logic [39:0]          prod;
   logic [2*SampleW-1:0] sq_full;
   logic [2*SqW-1:0]     quad_full;
   logic [NbW-1:0]       nb;
   logic [RawBinW-1:0]   bin_clamped;

   assign s2_load      = !s2_valid_ff || push_ready;
   assign s1_move      = s1_valid_ff && s2_load;
   assign req_if.ready = !s1_valid_ff || s1_move;

   always_comb begin
      y_ext      = {s1_sample_ff[SampleW-1], s1_sample_ff};
      a_ext      = s1_sample_ff[SampleW-1] ? (~y_ext + 1'b1) : y_ext;
      mag        = a_ext[SampleW-1:0];
      diff       = y_ext - {cfg.range_low[SampleW-1], cfg.range_low};
      bin_offset = diff[SampleW-1:0];
      under      = s1_sample_ff < cfg.range_low;
      over       = !under && (s1_sample_ff >= cfg.range_high);
      prod       = 40'(bin_offset) * 40'(cfg.bin_scale);
      sq_full    = 32'(mag) * 32'(mag);
   end

   always_comb begin
      quad_full = 62'(s2_sq_ff) * 62'(s2_sq_ff);
      nb        = clamp_bins(cfg.bins_in_use, BinsLim);
      bin_clamped = (s2_raw_ff >= RawBinW'(nb)) ? RawBinW'(nb - 1'b1) : s2_raw_ff;
      push_valid        = s2_valid_ff;
      push_item.flush   = s2_flush_ff;
      push_item.sample  = s2_sample_ff;
      push_item.sq      = s2_sq_ff;
      push_item.quad    = quad_full[60:32];
      push_item.under   = s2_under_ff;
      push_item.over    = s2_over_ff;
      push_item.bin     = bin_clamped[BinIdxW-1:0];
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) s1_valid_in = 1'b0;
      if (req_if.valid && req_if.ready) s1_valid_in = 1'b1;
      s2_valid_in = s2_valid_ff;
      if (s2_load) s2_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (req_if.valid && req_if.ready) begin
         s1_flush_ff  <= req_if.mode;
         s1_sample_ff <= req_if.sample;
      end
      if (s1_move) begin
         s2_flush_ff  <= s1_flush_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_sq_ff     <= sq_full[SqW-1:0];
         s2_under_ff  <= under;
         s2_over_ff   <= over;
         s2_raw_ff    <= prod[39:28];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/hmacc_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on hmacc_pkg.
`default_nettype none

module hmacc_queue
   import hmacc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire item_type push_item,
   output logic          push_ready,
   input  wire logic     pop,
   output logic          not_empty,
   output item_type      head
);

   localparam int PtrW = $clog2(QueueDepth);

   item_type        slot_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]   fill_ff, fill_in;
   logic            do_push, do_pop;

   assign push_ready = fill_ff != (PtrW+1)'(QueueDepth);
   assign not_empty  = fill_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && not_empty;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + 1'b1;
      if (do_pop && !do_push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

`default_nettype wire

FILE: rtl/core/hmacc_back.sv
// Back end: accumulates sums and bin counts, divides for the means, emits bin results.
// Depends on hmacc_pkg and hmacc_if.
`default_nettype none

module hmacc_back
   import hmacc_pkg::*;
#(
   parameter int BINS = 64
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     not_empty,
   input  wire item_type head,
   output logic          pop,
   hmacc_rsp_if.source   rsp_if
);

   localparam int AddrW = (BINS > 1) ? $clog2(BINS) : 1;
   localparam logic [NbW-1:0] BinsLim = NbW'(BINS);
   localparam logic [5:0] DivSteps = 6'(DividendW);

   typedef enum logic [2:0] {
      ST_IDLE, ST_INC, ST_DIV_SETUP, ST_DIV, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
   } state_type;

   state_type state_ff;
   logic [CountW-1:0] count_mem [BINS];
   logic [BINS-1:0]   present_ff;
   logic [CountW-1:0] rd_data_ff;
   logic              rd_hit_ff;
   logic [BinIdxW-1:0] rd_addr, inc_bin_ff, emit_bin_ff;
   logic               mem_we;
   logic [CountW-1:0]  mem_wdata;

   logic signed [SumFirstW-1:0] sum1_ff;
   logic [SumSecW-1:0]  sum2_ff;
   logic [SumFourW-1:0] sum4_ff;
   logic [CountW-1:0]   under_ff, over_ff;
   logic [SiteW-1:0]    site_ff;
   logic [MeasW-1:0]    meas_ff;
   logic [BlockW-1:0]   block_ff;
   logic                emit_pend_ff;

   logic [DivisorW-1:0]  div_ff;
   logic                 neg_ff;
   logic [DividendW-1:0] q1_ff, q2_ff, q4_ff;
   logic [DivisorW-1:0]  r1_ff, r2_ff, r4_ff;
   logic [5:0]           step_ff;

   logic [NtW-1:0]   nt;
   logic [NbW-1:0]   nb;
   logic [MeasW-1:0] mpb;
   logic [NtW-1:0]   site_next;
   logic [MeasW-1:0] meas_next;
   logic [SumFirstW-1:0] mag1;
   logic [28:0]      div_prod;
   logic signed [SampleW-1:0] m1;
   logic [SqW-1:0]   m2;
   logic [QuadW-1:0] m4;
   logic             last_bin;

   // One restoring step: shift the next dividend bit into the remainder.
   function automatic logic [DivisorW+DividendW-1:0] div_step(
         input logic [DivisorW-1:0] rem, input logic [DividendW-1:0] q,
         input logic [DivisorW-1:0] d);
      logic [DivisorW:0]   sh;
      logic [DivisorW-1:0] r;
      logic                bit_q;
      sh    = {rem, q[DividendW-1]};
      bit_q = sh >= {1'b0, d};
      r     = bit_q ? DivisorW'(sh - {1'b0, d}) : sh[DivisorW-1:0];
      return {r, q[DividendW-2:0], bit_q};
   endfunction

   always_comb begin
      nt        = clamp_nt(cfg.sites);
      nb        = clamp_bins(cfg.bins_in_use, BinsLim);
      mpb       = (cfg.meas_per_block == '0) ? MeasW'(1) : cfg.meas_per_block;
      site_next = NtW'(site_ff) + 1'b1;
      meas_next = meas_ff + 1'b1;
      mag1      = sum1_ff[SumFirstW-1] ? SumFirstW'(-sum1_ff) : SumFirstW'(sum1_ff);
      div_prod  = 29'(meas_ff) * 29'(nt);
      last_bin  = (NbW'(emit_bin_ff) + 1'b1) == nb;
      if (neg_ff) m1 = (q1_ff > DividendW'(32768)) ? 16'sh8000 : SampleW'(-q1_ff);
      else        m1 = (q1_ff > DividendW'(32767)) ? 16'sh7FFF : SampleW'(q1_ff);
      m2 = (q2_ff > DividendW'(1073741824)) ? SqW'(1073741824) : q2_ff[SqW-1:0];
      m4 = (q4_ff > DividendW'(268435456)) ? QuadW'(268435456) : q4_ff[QuadW-1:0];
      pop       = (state_ff == ST_IDLE) && not_empty;
      rd_addr   = (state_ff == ST_IDLE) ? head.bin : emit_bin_ff;
      mem_we    = state_ff == ST_INC;
      mem_wdata = (rd_hit_ff ? rd_data_ff : '0) + 1'b1;
   end

   // Bin count store, one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (mem_we) count_mem[inc_bin_ff[AddrW-1:0]] <= mem_wdata;
      rd_data_ff <= count_mem[rd_addr[AddrW-1:0]];
      rd_hit_ff  <= present_ff[rd_addr[AddrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         sum1_ff      <= '0;
         sum2_ff      <= '0;
         sum4_ff      <= '0;
         under_ff     <= '0;
         over_ff      <= '0;
         site_ff      <= '0;
         meas_ff      <= '0;
         block_ff     <= '0;
         emit_pend_ff <= 1'b0;
         rsp_if.valid <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (not_empty) begin
                  if (head.flush) begin
                     if (site_ff == '0 && meas_ff != '0) state_ff <= ST_DIV_SETUP;
                  end else begin
                     sum1_ff <= sum1_ff + SumFirstW'(head.sample);
                     sum2_ff <= sum2_ff + SumSecW'(head.sq);
                     sum4_ff <= sum4_ff + SumFourW'(head.quad);
                     if (head.under) under_ff <= under_ff + 1'b1;
                     else if (head.over) over_ff <= over_ff + 1'b1;
                     if (site_next >= nt) begin
                        site_ff <= '0;
                        meas_ff <= meas_next;
                     end else begin
                        site_ff <= site_next[SiteW-1:0];
                     end
                     emit_pend_ff <= (site_next >= nt) && (meas_next >= mpb);
                     inc_bin_ff   <= head.bin;
                     if (!head.under && !head.over) state_ff <= ST_INC;
                     else if ((site_next >= nt) && (meas_next >= mpb))
                        state_ff <= ST_DIV_SETUP;
                  end
               end
            end
            ST_INC: begin
               present_ff[inc_bin_ff[AddrW-1:0]] <= 1'b1;
               state_ff <= emit_pend_ff ? ST_DIV_SETUP : ST_IDLE;
            end
            ST_DIV_SETUP: begin
               div_ff   <= div_prod[DivisorW-1:0];
               neg_ff   <= sum1_ff[SumFirstW-1];
               q1_ff    <= DividendW'(mag1);
               q2_ff    <= sum2_ff;
               q4_ff    <= DividendW'(sum4_ff);
               r1_ff    <= '0;
               r2_ff    <= '0;
               r4_ff    <= '0;
               step_ff  <= DivSteps;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               {r1_ff, q1_ff} <= div_step(r1_ff, q1_ff, div_ff);
               {r2_ff, q2_ff} <= div_step(r2_ff, q2_ff, div_ff);
               {r4_ff, q4_ff} <= div_step(r4_ff, q4_ff, div_ff);
               step_ff <= step_ff - 1'b1;
               if (step_ff == 6'd1) begin
                  emit_bin_ff <= '0;
                  state_ff    <= ST_EMIT_RD;
               end
            end
            ST_EMIT_RD: state_ff <= ST_EMIT_LD;
            ST_EMIT_LD: begin
               rsp_if.valid              <= 1'b1;
               rsp_if.block_index        <= block_ff;
               rsp_if.bin_index          <= emit_bin_ff;
               rsp_if.bin_count          <= rd_hit_ff ? rd_data_ff : '0;
               rsp_if.under_count        <= under_ff;
               rsp_if.over_count         <= over_ff;
               rsp_if.block_meas         <= meas_ff;
               rsp_if.mean_first         <= m1;
               rsp_if.mean_second        <= m2;
               rsp_if.mean_fourth        <= m4;
               rsp_if.last_of_block      <= last_bin;
               state_ff                  <= ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
               if (rsp_if.ready) begin
                  rsp_if.valid <= 1'b0;
                  if (rsp_if.last_of_block) begin
                     // Block done: drop all counts and sums, advance the block number.
                     block_ff     <= block_ff + 1'b1;
                     present_ff   <= '0;
                     sum1_ff      <= '0;
                     sum2_ff      <= '0;
                     sum4_ff      <= '0;
                     under_ff     <= '0;
                     over_ff      <= '0;
                     site_ff      <= '0;
                     meas_ff      <= '0;
                     emit_pend_ff <= 1'b0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     emit_bin_ff <= emit_bin_ff + 1'b1;
                     state_ff    <= ST_EMIT_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/block_histogram_moment_accumulator_unit.sv
// Top level of the blocked histogram moment accumulator: CSR block and part wiring.
// Depends on hmacc_pkg, hmacc_if, hmacc_front, hmacc_queue and hmacc_back.
//
//   channel   direction  carries
//   req_if    in         mode, sample (one Q4.12 sample or a flush)
//   rsp_if    out        one result per active bin of a closed block
//   csr_*     in/out     APB-style register port, register i at byte 4*i
//
// A sample passes two front stages (powers, bin index) into a four-entry queue.
// The back end takes one queued item each cycle it is idle; an in-range sample
// then passes through ST_INC for the read-modify-write of its bin count.
// Closing a block runs ST_DIV_SETUP and the shared-step mean division in ST_DIV,
// then each bin result passes ST_EMIT_RD, ST_EMIT_LD and ST_EMIT_WAIT, where it
// waits for the output to take it. The front keeps accepting until the queue
// fills. Reset is synchronous; all counts read as zero after it.
`default_nettype none

module block_histogram_moment_accumulator_unit
   import hmacc_pkg::*;
#(
   parameter int BINS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   hmacc_req_if.sink                req_if,
   hmacc_rsp_if.source              rsp_if,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0]      csr_prdata,
   output logic                     csr_pready
);

   cfg_type     cfg_ff;
   csr_reg_type reg_sel;
   logic        csr_write;

   logic     push_valid, push_ready, pop, not_empty;
   item_type push_item, head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[4:2]);

   // Hold configuration; the user must write only while the block is idle, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_low      <= RangeLowReset;
         cfg_ff.range_high     <= RangeHighReset;
         cfg_ff.bin_scale      <= BinScaleReset;
         cfg_ff.bins_in_use    <= BinsReset;
         cfg_ff.sites          <= SitesReset;
         cfg_ff.meas_per_block <= MeasReset;
      end else if (csr_write) begin
         case (reg_sel)
            REG_RANGE_LOW:  cfg_ff.range_low      <= csr_pwdata[15:0];
            REG_RANGE_HIGH: cfg_ff.range_high     <= csr_pwdata[15:0];
            REG_BIN_SCALE:  cfg_ff.bin_scale      <= csr_pwdata[ScaleW-1:0];
            REG_BINS:       cfg_ff.bins_in_use    <= csr_pwdata[NbW-1:0];
            REG_SITES:      cfg_ff.sites          <= csr_pwdata[NtW-1:0];
            REG_MEAS:       cfg_ff.meas_per_block <= csr_pwdata[MeasW-1:0];
            default: ;
         endcase
      end
   end

   // Return the register value; unmapped addresses read zero.
   always_comb begin
      case (reg_sel)
         REG_RANGE_LOW:  csr_prdata = CsrDataW'(unsigned'(cfg_ff.range_low));
         REG_RANGE_HIGH: csr_prdata = CsrDataW'(unsigned'(cfg_ff.range_high));
         REG_BIN_SCALE:  csr_prdata = CsrDataW'(cfg_ff.bin_scale);
         REG_BINS:       csr_prdata = CsrDataW'(cfg_ff.bins_in_use);
         REG_SITES:      csr_prdata = CsrDataW'(cfg_ff.sites);
         REG_MEAS:       csr_prdata = CsrDataW'(cfg_ff.meas_per_block);
         default:        csr_prdata = '0;
      endcase
   end

   hmacc_front #(.BINS(BINS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg_ff),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   hmacc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   hmacc_back #(.BINS(BINS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking bench for block_histogram_moment_accumulator_unit.
// Depends on hmacc_pkg, hmacc_if and the RTL; models bins, counts and moment means.
`default_nettype none

module tb_top;
   import hmacc_pkg::*;

   localparam int NumBins   = 64;
   localparam int CycleCap  = 1000000;
   localparam int DrainWait = 400;   // covers mean division plus a queue of samples

   // One bin result of a closed block, as seen on the rsp channel
   typedef struct {
      logic [BlockW-1:0]  block_index;
      logic [BinIdxW-1:0] bin_index;
      logic [CountW-1:0]  bin_count;
      logic [CountW-1:0]  under_count;
      logic [CountW-1:0]  over_count;
      logic [MeasW-1:0]   block_meas;
      logic [SampleW-1:0] mean_first;
      logic [SqW-1:0]     mean_second;
      logic [QuadW-1:0]   mean_fourth;
      logic               last_of_block;
   } bin_result_type;

   // Histogram and moment predictor plus the store of pending bin results
   class histo_scoreboard;
      logic [15:0]       range_low, range_high;
      logic [23:0]       bin_scale;
      logic [6:0]        bins_in_use;
      logic [12:0]       sites;
      logic [15:0]       meas_per_block;
      logic [27:0]       bin_counts [NumBins];
      longint            sum_first;
      longint unsigned   sum_second, sum_fourth;
      logic [27:0]       under_total, over_total;
      int                site_count;
      logic [15:0]       meas_count;
      logic [31:0]       block_count;
      bin_result_type    pending_bins [$];
      int                errors;

      function void reset_state();
         range_low      = RangeLowReset;
         range_high     = RangeHighReset;
         bin_scale      = BinScaleReset;
         bins_in_use    = BinsReset;
         sites          = SitesReset;
         meas_per_block = MeasReset;
         block_count    = '0;
         errors         = 0;
         clear_block();
      endfunction

      function void clear_block();
         foreach (bin_counts[i]) bin_counts[i] = '0;
         sum_first   = 0;
         sum_second  = 0;
         sum_fourth  = 0;
         under_total = '0;
         over_total  = '0;
         site_count  = 0;
         meas_count  = '0;
      endfunction

      function void write_reg(csr_reg_type idx, logic [31:0] value);
         case (idx)
            REG_RANGE_LOW:  range_low      = value[15:0];
            REG_RANGE_HIGH: range_high     = value[15:0];
            REG_BIN_SCALE:  bin_scale      = value[23:0];
            REG_BINS:       bins_in_use    = value[6:0];
            REG_SITES:      sites          = value[12:0];
            REG_MEAS:       meas_per_block = value[15:0];
            default: ;
         endcase
      endfunction

      function int active_bins();
         int n;
         n = bins_in_use;
         if (n < 1) n = 1;
         if (n > NumBins) n = NumBins;
         return n;
      endfunction

      function int sites_eff();
         int n;
         n = sites;
         if (n < 2) n = 2;
         if (n > 4096) n = 4096;
         return n;
      endfunction

      // Close the block: compute saturated means and queue one result per active bin
      function void close_block();
         longint unsigned divisor, mag, q, m2, m4;
         longint          m1;
         int              nb;
         bin_result_type  r;
         divisor = longint'(meas_count) * sites_eff();
         nb      = active_bins();
         mag     = (sum_first < 0) ? -sum_first : sum_first;
         q       = mag / divisor;
         if (sum_first < 0) m1 = (q > 32768) ? -32768 : -longint'(q);
         else m1 = (q > 32767) ? 32767 : longint'(q);
         m2 = sum_second / divisor;
         m4 = sum_fourth / divisor;
         if (m2 > 64'd1073741824) m2 = 64'd1073741824;
         if (m4 > 64'd268435456) m4 = 64'd268435456;
         for (int b = 0; b < nb; b++) begin
            r.block_index        = block_count;
            r.bin_index          = b[5:0];
            r.bin_count          = bin_counts[b];
            r.under_count        = under_total;
            r.over_count         = over_total;
            r.block_meas         = meas_count;
            r.mean_first         = m1[15:0];
            r.mean_second        = m2[30:0];
            r.mean_fourth        = m4[28:0];
            r.last_of_block      = (b + 1 == nb);
            pending_bins.push_back(r);
         end
         block_count++;
         clear_block();
      endfunction

      // Note one accepted request transaction
      function void note_request(logic flush, logic [15:0] sample);
         int              y, lo, hi, mpb;
         longint unsigned a, a2, bin;
         if (flush) begin
            if (site_count == 0 && meas_count >= 1) close_block();
            return;
         end
         y   = int'($signed(sample));
         lo  = int'($signed(range_low));
         hi  = int'($signed(range_high));
         mpb = (meas_per_block == 0) ? 1 : meas_per_block;
         a   = (y < 0) ? -y : y;
         a2  = a * a;
         sum_first  += y;
         sum_second += a2;
         sum_fourth += (a2 * a2) >> 32;
         if (y < lo) under_total++;
         else if (y >= hi) over_total++;
         else begin
            bin = (longint'(y - lo) * bin_scale) >> 28;
            if (bin >= active_bins()) bin = active_bins() - 1;
            bin_counts[bin]++;
         end
         site_count++;
         if (site_count >= sites_eff()) begin
            site_count = 0;
            meas_count++;
            if (meas_count >= mpb) close_block();
         end
      endfunction

      function void report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("mismatch %s: got %0h want %0h", what, got, want);
      endfunction

      // Check one accepted result transaction against the oldest pending one
      function void check_result(bin_result_type got);
         bin_result_type want;
         if (pending_bins.size() == 0) begin
            report("unexpected result, bin", got.bin_index, 0);
            return;
         end
         want = pending_bins.pop_front();
         if (got.block_index !== want.block_index)
            report("block_index", got.block_index, want.block_index);
         if (got.bin_index !== want.bin_index)
            report("bin_index", got.bin_index, want.bin_index);
         if (got.bin_count !== want.bin_count)
            report("bin_count", got.bin_count, want.bin_count);
         if (got.under_count !== want.under_count)
            report("under_count", got.under_count, want.under_count);
         if (got.over_count !== want.over_count)
            report("over_count", got.over_count, want.over_count);
         if (got.block_meas !== want.block_meas)
            report("block_meas", got.block_meas, want.block_meas);
         if (got.mean_first !== want.mean_first)
            report("mean_first", got.mean_first, want.mean_first);
         if (got.mean_second !== want.mean_second)
            report("mean_second", got.mean_second, want.mean_second);
         if (got.mean_fourth !== want.mean_fourth)
            report("mean_fourth", got.mean_fourth, want.mean_fourth);
         if (got.last_of_block !== want.last_of_block)
            report("last_of_block", got.last_of_block, want.last_of_block);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_psel, csr_penable, csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata, csr_prdata;
   logic                csr_pready;
   int                  sender_idle_pct, receiver_idle_pct;
   int                  cycle_count = 0;
   histo_scoreboard     histo;

   hmacc_req_if req_ch ();
   hmacc_rsp_if rsp_ch ();

   block_histogram_moment_accumulator_unit #(.BINS(NumBins)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Cycle watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleCap) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Result side: check each accepted transaction, then randomize ready for the next edge
   always @(posedge clock) begin
      bin_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.block_index        = rsp_ch.block_index;
         got.bin_index          = rsp_ch.bin_index;
         got.bin_count          = rsp_ch.bin_count;
         got.under_count        = rsp_ch.under_count;
         got.over_count         = rsp_ch.over_count;
         got.block_meas         = rsp_ch.block_meas;
         got.mean_first         = rsp_ch.mean_first;
         got.mean_second        = rsp_ch.mean_second;
         got.mean_fourth        = rsp_ch.mean_fourth;
         got.last_of_block      = rsp_ch.last_of_block;
         histo.check_result(got);
      end
      rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Write one register: setup cycle, then access cycle; the write lands at the access edge
   task automatic csr_write(csr_reg_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      histo.write_reg(idx, value);
   endtask

   task automatic program_block(int lo, int hi, int scale, int nbins, int nsites, int mpb);
      csr_write(REG_RANGE_LOW, 32'(lo));
      csr_write(REG_RANGE_HIGH, 32'(hi));
      csr_write(REG_BIN_SCALE, 32'(scale));
      csr_write(REG_BINS, 32'(nbins));
      csr_write(REG_SITES, 32'(nsites));
      csr_write(REG_MEAS, 32'(mpb));
   endtask

   // Drive one request transaction; hold valid until ready was seen at an edge
   task automatic send_request(logic flush, logic [15:0] sample);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.mode   <= flush;
      req_ch.sample <= sample;
      do @(posedge clock); while (!req_ch.ready);
      histo.note_request(flush, sample);
   endtask

   // Let the block drain every pending result and finish any queued samples
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (histo.pending_bins.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   // Mix of edge values, in-range values and full-range noise
   function automatic logic [15:0] pick_sample();
      int lo, hi, k;
      lo = int'($signed(histo.range_low));
      hi = int'($signed(histo.range_high));
      k  = $urandom_range(99);
      if (k < 5) return 16'h8000;
      if (k < 10) return 16'h7FFF;
      if (k < 14) return 16'(lo);
      if (k < 18) return 16'(hi);
      if (k < 21) return 16'(lo - 1);
      if (k < 24) return 16'(hi - 1);
      if (k < 60 && hi > lo) return 16'($urandom_range(hi - lo - 1) + lo);
      return 16'($urandom);
   endfunction

   task automatic random_traffic(int n, int flush_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < flush_pct) send_request(1'b1, 16'($urandom));
         else send_request(1'b0, pick_sample());
      end
      // close whatever partial block is left when it sits on a measurement boundary
      send_request(1'b1, 16'h0000);
   endtask

   initial begin
      int lo, hi;
      histo = new();
      histo.reset_state();
      sender_idle_pct   = 22;
      receiver_idle_pct = 59;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.mode    <= 1'b0;
      req_ch.sample  <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: two-site measurements, two measurements per block, 8 bins
      program_block(-16384, 16384, 32'h020000, 8, 2, 2);
      send_request(1'b1, 16'h0000);                  // flush with nothing accumulated
      send_request(1'b0, 16'h8000);                  // most negative: underflow
      send_request(1'b1, 16'hFFFF);                  // flush mid-measurement, ignored
      send_request(1'b0, 16'h7FFF);                  // most positive: overflow
      send_request(1'b0, 16'h0000);
      send_request(1'b0, 16'hFFFF);                  // closes the block
      send_request(1'b0, 16'hC000);                  // exactly on the lower edge
      send_request(1'b0, 16'h4000);                  // exactly on the upper edge
      send_request(1'b0, 16'h3FFF);
      send_request(1'b0, 16'hBFFF);                  // closes the block
      send_request(1'b0, 16'd100);
      send_request(1'b0, 16'd200);
      send_request(1'b1, 16'h5555);                  // flush on a boundary: partial block
      wait_drained();

      // Widest range, bins past the active count, counts clamped up
      program_block(-32768, 32767, 32'hFFFFFF, 127, 0, 0);
      random_traffic(14, 5);
      wait_drained();

      // Inverted range: everything under or over
      program_block(4096, -4096, 0, 0, 1, 3);
      random_traffic(14, 10);
      wait_drained();

      sender_idle_pct   = 59;
      receiver_idle_pct = 22;
      for (int p = 0; p < 3; p++) begin
         lo = $urandom_range(16384) - 16384;
         hi = lo + $urandom_range(30000) + 1;
         if (hi > 32767) hi = 32767;
         program_block(lo, hi, $urandom_range(32'hFFFFFF), $urandom_range(64, 1),
                       $urandom_range(6, 2), $urandom_range(4, 1));
         random_traffic(14, 12);
         wait_drained();
      end

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      // Block that never fills: closed by flushes only
      program_block(-8192, 8192, 32'h080000, 16, 3, 65535);
      random_traffic(14, 20);
      wait_drained();

      if (histo.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
